@@ sv/sdnf_pkg.sv @@
// Shared types, constants and the segment table of the number display formatter.
package sdnf_pkg;

    // Character cells on the display and bits per cell digit.
    localparam int DIGITS    = 10;
    localparam int DIG_W     = 4;
    localparam int VALUE_W   = 32;
    localparam int CONV_STEPS = VALUE_W;

    // Command kinds on the input channel.
    localparam logic [2:0] KIND_CLEAR    = 3'd0;
    localparam logic [2:0] KIND_BIN      = 3'd1;
    localparam logic [2:0] KIND_DEC_U    = 3'd2;
    localparam logic [2:0] KIND_DEC_S    = 3'd3;
    localparam logic [2:0] KIND_HEX_U    = 3'd4;
    localparam logic [2:0] KIND_HEX_S    = 3'd5;

    localparam logic [31:0] SIGN_BIT  = 32'h8000_0000;
    localparam logic [31:0] MAG_MASK  = 32'h7FFF_FFFF;
    localparam logic [31:0] DEC_LIMIT = 32'd999_999_999;
    localparam logic [31:0] DEC_NEG_LIMIT = SIGN_BIT + DEC_LIMIT;

    // Segment codes for the non-digit characters.
    localparam logic [7:0] SEG_BLANK = 8'h00;
    localparam logic [7:0] SEG_MINUS = 8'h01;
    localparam logic [7:0] SEG_B     = 8'hC7;
    localparam logic [7:0] SEG_H     = 8'hC3;

    // Bus values of the write sequence.
    localparam logic [3:0] ADDR_UNLOCK = 4'hF;
    localparam logic [3:0] DATA_UNLOCK = 4'h1;
    localparam logic [3:0] ADDR_CELLS  = 4'h0;

    // Write step numbering: the clear sequence uses every step, a show
    // sequence starts at the cell address write.
    localparam int STEP_W = 5;
    localparam logic [STEP_W-1:0] STEP_UNLOCK_ADDR = 5'd0;
    localparam logic [STEP_W-1:0] STEP_UNLOCK_DATA = 5'd1;
    localparam logic [STEP_W-1:0] STEP_CELL_ADDR   = 5'd2;
    localparam logic [STEP_W-1:0] STEP_DATA_FIRST  = 5'd3;
    localparam logic [STEP_W-1:0] STEP_LAST        = 5'd22;

    typedef enum logic [1:0] {
        MODE_CLEAR,
        MODE_BIN,
        MODE_DEC,
        MODE_HEX
    } t_mode;

    typedef struct packed {
        t_mode              mode;
        logic               neg;
        logic [VALUE_W-1:0] mag;
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SEND
    } t_back_state;

    typedef logic [DIGITS-1:0][DIG_W-1:0] t_digits;

    function automatic logic [7:0] seg_of_digit(input logic [3:0] d);
        logic [7:0] s;
        unique case (d)
            4'h0: s = 8'hEE;
            4'h1: s = 8'h60;
            4'h2: s = 8'h2F;
            4'h3: s = 8'h6D;
            4'h4: s = 8'hE1;
            4'h5: s = 8'hCD;
            4'h6: s = 8'hCF;
            4'h7: s = 8'h68;
            4'h8: s = 8'hEF;
            4'h9: s = 8'hED;
            4'hA: s = 8'hEB;
            4'hB: s = 8'hC7;
            4'hC: s = 8'h07;
            4'hD: s = 8'h67;
            4'hE: s = 8'h8F;
            4'hF: s = 8'h8B;
        endcase
        return s;
    endfunction

endpackage

@@ sv/segment_display_number_formatter.sv @@
// Top level of the seven-segment number display formatter.
//
// Usage: a command beat on the input channel (i_valid/o_ready) carries a
// kind and a 32-bit value. Kind 0 unlocks and clears the display; kinds 1
// to 5 show the value as binary (low 8 bits), unsigned or signed decimal,
// or unsigned or signed hex. Kinds 6 and 7 are accepted and produce nothing.
// Each command yields a run of output beats (o_valid/i_ready), one per
// display bus write: reg_select, a 4-bit nibble, and last on the final
// write. A clear gives 23 beats, a show command 21 beats.
// Throughput: one beat per cycle while sending and the receiver is ready.
// A decimal command first runs the bit-serial binary to BCD conversion.
// The first beat of a command is offered after it has passed the queue,
// the sequencer state register (and for decimal the conversion) and the
// registered output beat. A two-entry command queue sits between the
// front end and the sequencer, so new commands are taken while one is
// being sent.
// A stalled receiver holds the registered output beat; the sequencer
// waits and the queue fills, after which o_ready drops.
// Reset empties the queue and drops any partly sent sequence.
module segment_display_number_formatter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_kind,
    input  logic [31:0] i_value,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_reg_select,
    output logic [3:0]  o_nibble,
    output logic        o_last
);
    import sdnf_pkg::*;

    logic w_q_full;
    logic w_push;
    t_cmd w_push_cmd;
    logic w_pop;
    logic w_q_valid;
    t_cmd w_q_cmd;

    // Classification of each command beat into a display mode and magnitude.
    sdnf_front u_front (
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_kind   (i_kind),
        .i_value  (i_value),
        .i_q_full (w_q_full),
        .o_push   (w_push),
        .o_cmd    (w_push_cmd)
    );

    // Decouples command intake from the write sequencer.
    sdnf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_cmd   (w_q_cmd)
    );

    // Digit conversion and bus write sequencing with a registered output.
    sdnf_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (w_q_valid),
        .i_q_cmd      (w_q_cmd),
        .o_q_pop      (w_pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_reg_select (o_reg_select),
        .o_nibble     (o_nibble),
        .o_last       (o_last)
    );

endmodule

@@ sv/sdnf_front.sv @@
// Front end: accepts commands, drops unknown kinds and resolves sign and clamping.
module sdnf_front (
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [2:0]           i_kind,
    input  logic [31:0]          i_value,
    input  logic                 i_q_full,
    output logic                 o_push,
    output sdnf_pkg::t_cmd       o_cmd
);
    import sdnf_pkg::*;

    logic w_known;

    always_comb begin
        o_cmd.mode = MODE_CLEAR;
        o_cmd.neg  = 1'b0;
        o_cmd.mag  = i_value;
        w_known    = 1'b1;
        unique case (i_kind)
            KIND_CLEAR: begin
                o_cmd.mode = MODE_CLEAR;
            end
            KIND_BIN: begin
                o_cmd.mode = MODE_BIN;
            end
            KIND_DEC_U: begin
                o_cmd.mode = MODE_DEC;
            end
            KIND_DEC_S: begin
                o_cmd.mode = MODE_DEC;
                // Minus zero is not negative and shows as a plain number.
                if (i_value > SIGN_BIT) begin
                    o_cmd.neg = 1'b1;
                    o_cmd.mag = (i_value > DEC_NEG_LIMIT) ? DEC_LIMIT : (i_value & MAG_MASK);
                end
            end
            KIND_HEX_U: begin
                o_cmd.mode = MODE_HEX;
            end
            KIND_HEX_S: begin
                o_cmd.mode = MODE_HEX;
                if (i_value > SIGN_BIT) begin
                    o_cmd.neg = 1'b1;
                    o_cmd.mag = i_value & MAG_MASK;
                end
            end
            default: begin
                w_known = 1'b0;
            end
        endcase
    end

    assign o_ready = !i_q_full;
    assign o_push  = i_valid && !i_q_full && w_known;

endmodule

@@ sv/sdnf_queue.sv @@
// Two-entry command queue between the front end and the write sequencer.
module sdnf_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  sdnf_pkg::t_cmd       i_cmd,
    output logic                 o_full,
    input  logic                 i_pop,
    output logic                 o_valid,
    output sdnf_pkg::t_cmd       o_cmd
);
    import sdnf_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    logic w_push;
    logic w_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 2'd1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

@@ sv/sdnf_back.sv @@
// Back end: converts one command to cell digits and sequences the bus writes.
module sdnf_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_valid,
    input  sdnf_pkg::t_cmd       i_q_cmd,
    output logic                 o_q_pop,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic                 o_reg_select,
    output logic [3:0]           o_nibble,
    output logic                 o_last
);
    import sdnf_pkg::*;

    t_back_state         r_state, n_state;
    t_mode               r_mode, n_mode;
    logic                r_neg, n_neg;
    t_digits             r_dig, n_dig;
    logic [VALUE_W-1:0]  r_bin, n_bin;
    logic [4:0]          r_cnt, n_cnt;
    logic [STEP_W-1:0]   r_step, n_step;
    logic                r_out_valid, n_out_valid;
    logic                r_out_rs, n_out_rs;
    logic [3:0]          r_out_nib, n_out_nib;
    logic                r_out_last, n_out_last;

    t_digits             w_adj;
    logic [3:0]          w_used;
    logic [STEP_W-1:0]   w_j;
    logic [3:0]          w_cell;
    logic [7:0]          w_seg;
    logic                w_fire;

    // Add-3 adjustment of each BCD digit before the next shift.
    always_comb begin
        for (int i = 0; i < DIGITS; i++) begin
            w_adj[i] = (r_dig[i] >= 4'd5) ? r_dig[i] + 4'd3 : r_dig[i];
        end
    end

    // Count of significant digits, at least one so that zero shows '0'.
    always_comb begin
        w_used = 4'd1;
        for (int i = 0; i < DIGITS; i++) begin
            if (r_dig[i] != '0) begin
                w_used = 4'(i + 1);
            end
        end
    end

    // Cell being sent: highest cell first, low nibble before high nibble.
    assign w_j    = r_step - STEP_DATA_FIRST;
    assign w_cell = 4'(DIGITS - 1) - 4'(w_j[STEP_W-1:1]);

    always_comb begin
        w_seg = SEG_BLANK;
        unique case (r_mode)
            MODE_CLEAR: begin
                w_seg = SEG_BLANK;
            end
            MODE_BIN: begin
                if (w_cell == 4'(DIGITS - 1)) begin
                    w_seg = SEG_B;
                end else if (w_cell < 4'd8) begin
                    w_seg = seg_of_digit(r_dig[w_cell]);
                end
            end
            MODE_DEC, MODE_HEX: begin
                if (r_mode == MODE_HEX && w_cell == 4'(DIGITS - 1)) begin
                    w_seg = SEG_H;
                end else if (w_cell < w_used) begin
                    w_seg = seg_of_digit(r_dig[w_cell]);
                end else if (r_neg && w_cell == w_used) begin
                    w_seg = SEG_MINUS;
                end
            end
        endcase
    end

    assign w_fire = (r_state == ST_SEND) && (!r_out_valid || i_ready);

    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_neg       = r_neg;
        n_dig       = r_dig;
        n_bin       = r_bin;
        n_cnt       = r_cnt;
        n_step      = r_step;
        n_out_valid = r_out_valid && !i_ready;
        n_out_rs    = r_out_rs;
        n_out_nib   = r_out_nib;
        n_out_last  = r_out_last;
        o_q_pop     = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_mode  = i_q_cmd.mode;
                    n_neg   = i_q_cmd.neg;
                    n_bin   = i_q_cmd.mag;
                    n_cnt   = '0;
                    n_dig   = '0;
                    unique case (i_q_cmd.mode)
                        MODE_CLEAR: begin
                            n_step  = STEP_UNLOCK_ADDR;
                            n_state = ST_SEND;
                        end
                        MODE_BIN: begin
                            for (int i = 0; i < 8; i++) begin
                                n_dig[i] = {3'b000, i_q_cmd.mag[i]};
                            end
                            n_step  = STEP_CELL_ADDR;
                            n_state = ST_SEND;
                        end
                        MODE_DEC: begin
                            n_state = ST_CONV;
                        end
                        MODE_HEX: begin
                            n_dig   = t_digits'({8'h00, i_q_cmd.mag});
                            n_step  = STEP_CELL_ADDR;
                            n_state = ST_SEND;
                        end
                    endcase
                end
            end
            ST_CONV: begin
                // One shift-and-adjust step of the binary to BCD conversion.
                // The whole digit vector moves up by one bit.
                n_dig = {w_adj[DIGITS-1][DIG_W-2:0], w_adj[DIGITS-2:0], r_bin[VALUE_W-1]};
                n_bin = {r_bin[VALUE_W-2:0], 1'b0};
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'(CONV_STEPS - 1)) begin
                    n_step  = STEP_CELL_ADDR;
                    n_state = ST_SEND;
                end
            end
            ST_SEND: begin
                if (w_fire) begin
                    n_out_valid = 1'b1;
                    n_out_last  = (r_step == STEP_LAST);
                    priority if (r_step == STEP_UNLOCK_ADDR) begin
                        n_out_rs  = 1'b0;
                        n_out_nib = ADDR_UNLOCK;
                    end else if (r_step == STEP_UNLOCK_DATA) begin
                        n_out_rs  = 1'b1;
                        n_out_nib = DATA_UNLOCK;
                    end else if (r_step == STEP_CELL_ADDR) begin
                        n_out_rs  = 1'b0;
                        n_out_nib = ADDR_CELLS;
                    end else begin
                        n_out_rs  = 1'b1;
                        n_out_nib = w_j[0] ? w_seg[7:4] : w_seg[3:0];
                    end
                    n_step = r_step + 5'd1;
                    if (r_step == STEP_LAST) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode     <= n_mode;
        r_neg      <= n_neg;
        r_dig      <= n_dig;
        r_bin      <= n_bin;
        r_cnt      <= n_cnt;
        r_step     <= n_step;
        r_out_rs   <= n_out_rs;
        r_out_nib  <= n_out_nib;
        r_out_last <= n_out_last;
    end

    assign o_valid      = r_out_valid;
    assign o_reg_select = r_out_rs;
    assign o_nibble     = r_out_nib;
    assign o_last       = r_out_last;

endmodule
